// ===== rtl/cstc_pkg.sv =====
package cstc_pkg;

    localparam int MaxNodes = 1024;
    localparam int MaxEdges = 4096;
    localparam int NodeW = 10;
    localparam int NodeCntW = 11;
    localparam int EdgeIdxW = 12;
    localparam int EdgeCntW = 13;
    localparam int CostW = 7;
    localparam int EdgeW = 28;
    localparam int TotalW = 17;
    localparam int PenW = 8;
    localparam int SumW = 20;
    localparam logic signed [PenW-1:0] PenLow = -8'sd100;
    localparam logic signed [PenW-1:0] PenHigh = 8'sd100;
    localparam logic [TotalW-1:0] TotalMax = 17'h1FFFF;

    localparam logic [1:0] AddrNodeCount = 2'd0;
    localparam logic [1:0] AddrWhiteNeeded = 2'd1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SORT_INIT,
        CMD_SORT_STEP,
        CMD_PASS_INIT,
        CMD_PAR_INIT,
        CMD_PICK_READ,
        CMD_PICK,
        CMD_FIND,
        CMD_UNITE,
        CMD_PASS_END,
        CMD_DONE
    } cmd_t;

    typedef struct packed {
        logic sort_done;
        logic par_done;
        logic picks_done;
        logic edge_ok;
        logic find_done;
        logic search_done;
    } status_t;

endpackage

// ===== rtl/cstc_datapath.sv =====
module cstc_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cstc_pkg::cmd_t                cmd,
    output cstc_pkg::status_t             status,
    input  logic                          load_en,
    input  logic [cstc_pkg::EdgeW-1:0]    load_edge,
    input  logic                          clear_total,
    input  logic [cstc_pkg::NodeCntW-1:0] node_count,
    input  logic [cstc_pkg::NodeW-1:0]    white_needed,
    output logic [cstc_pkg::TotalW-1:0]   total_cost,
    output logic                          found
);
    import cstc_pkg::*;

    logic [EdgeW-1:0]    edge_mem [MaxEdges];
    logic [EdgeIdxW-1:0] white_mem [MaxEdges];
    logic [EdgeIdxW-1:0] black_mem [MaxEdges];
    logic [NodeW-1:0]    parent_mem [MaxNodes];

    logic [EdgeCntW-1:0] edge_total_reg;
    logic [EdgeCntW-1:0] wlen_reg, blen_reg, wi_reg, bi_reg, sidx_reg;
    logic [CostW:0]      slev_reg;
    logic [EdgeW-1:0]    sedge_reg;
    logic                sedge_ok_reg;
    logic [EdgeIdxW-1:0] sidx_d_reg;
    logic signed [PenW:0] lo_reg, hi_reg, mid_reg;
    logic [NodeCntW-1:0] nodes_reg, pidx_reg;
    logic [EdgeW-1:0]    bedge_reg, cur_reg;
    logic [EdgeIdxW-1:0] wptr_reg, bptr_reg;
    logic                cur_white_reg;
    logic [NodeW-1:0]    fa_reg, fb_reg, fpar_reg;
    logic                fside_reg, fphase_reg;
    logic [NodeW-1:0]    fprev_reg;
    logic                fprev_ok_reg;
    logic [NodeW-1:0]    ra_reg;
    logic [NodeW:0]      whites_reg;
    logic signed [SumW-1:0] sum_reg;
    logic                found_reg;
    logic signed [SumW+1:0] ans_reg;
    logic [TotalW-1:0]   total_reg;

    logic signed [PenW:0] wcost, bcost;
    logic take_w;
    logic wleft, bleft;
    logic [NodeW-1:0] fnode;
    logic signed [SumW+1:0] cand;
    logic [EdgeIdxW-1:0] ea_addr;
    logic load_ok;

    // port A serves loading, the sort sweep and the white candidate
    assign load_ok = load_en && edge_total_reg < EdgeCntW'(MaxEdges);
    assign ea_addr = load_en ? edge_total_reg[EdgeIdxW-1:0] :
                     (cmd == CMD_SORT_STEP) ? sidx_reg[EdgeIdxW-1:0] : wptr_reg;

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            edge_mem[ea_addr] <= load_edge;
        end
        sedge_reg <= edge_mem[ea_addr];
        sidx_d_reg <= sidx_reg[EdgeIdxW-1:0];
        bedge_reg <= edge_mem[bptr_reg];
    end

    assign wleft = wi_reg < wlen_reg;
    assign bleft = bi_reg < blen_reg;
    assign wcost = $signed({2'b00, sedge_reg[26:20]}) + mid_reg;
    assign bcost = $signed({2'b00, bedge_reg[26:20]});
    assign take_w = !bleft || (wleft && wcost <= bcost);
    assign fnode = fside_reg ? fb_reg : fa_reg;

    always_ff @(posedge clk)
    begin
        wptr_reg <= white_mem[wi_reg[EdgeIdxW-1:0]];
        bptr_reg <= black_mem[bi_reg[EdgeIdxW-1:0]];
        fpar_reg <= parent_mem[fnode];
        if (cmd == CMD_PAR_INIT)
        begin
            parent_mem[pidx_reg[NodeW-1:0]] <= pidx_reg[NodeW-1:0];
        end
        else if (cmd == CMD_UNITE)
        begin
            parent_mem[fb_reg] <= ra_reg;
        end
        else if (cmd == CMD_FIND && fphase_reg && fprev_ok_reg)
        begin
            // path splitting: previous node now points at its grandparent
            parent_mem[fprev_reg] <= fpar_reg;
        end
        if (cmd == CMD_SORT_STEP && sedge_ok_reg && sedge_reg[26:20] == slev_reg[CostW-1:0])
        begin
            if (!sedge_reg[27])
            begin
                white_mem[wlen_reg[EdgeIdxW-1:0]] <= sidx_d_reg;
            end
            else
            begin
                black_mem[blen_reg[EdgeIdxW-1:0]] <= sidx_d_reg;
            end
        end
    end

    assign cand = $signed({{2{sum_reg[SumW-1]}}, sum_reg})
                - $signed({1'b0, white_needed}) * mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
            wlen_reg <= '0;
            blen_reg <= '0;
            sidx_reg <= '0;
            slev_reg <= '0;
            sedge_ok_reg <= 1'b0;
            lo_reg <= '0;
            hi_reg <= '0;
            mid_reg <= '0;
            found_reg <= 1'b0;
            ans_reg <= '0;
            total_reg <= '0;
            wi_reg <= '0;
            bi_reg <= '0;
            pidx_reg <= '0;
            nodes_reg <= '0;
            whites_reg <= '0;
            sum_reg <= '0;
            fside_reg <= 1'b0;
            fphase_reg <= 1'b0;
            fprev_reg <= '0;
            fprev_ok_reg <= 1'b0;
            cur_reg <= '0;
            cur_white_reg <= 1'b0;
            fa_reg <= '0;
            fb_reg <= '0;
            ra_reg <= '0;
        end
        else
        begin
            if (load_ok)
            begin
                edge_total_reg <= edge_total_reg + 1'b1;
            end
            if (clear_total)
            begin
                edge_total_reg <= '0;
            end
            fphase_reg <= 1'b0;
            case (cmd)
                CMD_SORT_INIT:
                begin
                    wlen_reg <= '0;
                    blen_reg <= '0;
                    sidx_reg <= '0;
                    slev_reg <= '0;
                    sedge_ok_reg <= 1'b0;
                    lo_reg <= (PenW+1)'(PenLow);
                    hi_reg <= (PenW+1)'(PenHigh);
                    found_reg <= 1'b0;
                    ans_reg <= '0;
                    nodes_reg <= (node_count > NodeCntW'(MaxNodes)) ?
                                 NodeCntW'(MaxNodes) : node_count;
                end
                CMD_SORT_STEP:
                begin
                    // sweep edges once per cost level; the edge memory read is registered
                    if (sedge_ok_reg && sedge_reg[26:20] == slev_reg[CostW-1:0])
                    begin
                        if (!sedge_reg[27]) wlen_reg <= wlen_reg + 1'b1;
                        else blen_reg <= blen_reg + 1'b1;
                    end
                    if (sidx_reg < edge_total_reg)
                    begin
                        sedge_ok_reg <= 1'b1;
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                    else
                    begin
                        sedge_ok_reg <= 1'b0;
                        sidx_reg <= '0;
                        if (sedge_ok_reg || edge_total_reg == '0)
                        begin
                            slev_reg <= slev_reg + 1'b1;
                        end
                    end
                end
                CMD_PASS_INIT:
                begin
                    mid_reg <= (PenW+1)'((lo_reg + hi_reg) / 2);
                    pidx_reg <= '0;
                    wi_reg <= '0;
                    bi_reg <= '0;
                    whites_reg <= '0;
                    sum_reg <= '0;
                end
                CMD_PAR_INIT:
                begin
                    pidx_reg <= pidx_reg + 1'b1;
                end
                CMD_PICK:
                begin
                    cur_reg <= take_w ? sedge_reg : bedge_reg;
                    cur_white_reg <= take_w;
                    if (take_w) wi_reg <= wi_reg + 1'b1;
                    else bi_reg <= bi_reg + 1'b1;
                    fa_reg <= take_w ? sedge_reg[9:0] : bedge_reg[9:0];
                    fb_reg <= take_w ? sedge_reg[19:10] : bedge_reg[19:10];
                    fside_reg <= 1'b0;
                    fprev_ok_reg <= 1'b0;
                end
                CMD_FIND:
                begin
                    if (!fphase_reg)
                    begin
                        fphase_reg <= 1'b1;
                    end
                    else if (fpar_reg == fnode)
                    begin
                        if (!fside_reg)
                        begin
                            ra_reg <= fnode;
                            fside_reg <= 1'b1;
                            fprev_ok_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        // step to the parent; its entry is read back through the registered parent memory port
                        fprev_reg <= fnode;
                        fprev_ok_reg <= 1'b1;
                        if (fside_reg) fb_reg <= fpar_reg;
                        else fa_reg <= fpar_reg;
                    end
                end
                CMD_UNITE:
                begin
                    // both ends on one tree: the edge would close a loop
                    if (ra_reg != fb_reg)
                    begin
                        sum_reg <= sum_reg + SumW'(cur_reg[26:20])
                                 + (cur_white_reg ? SumW'(mid_reg) : '0);
                        if (cur_white_reg) whites_reg <= whites_reg + 1'b1;
                    end
                end
                CMD_PASS_END:
                begin
                    if (whites_reg >= {1'b0, white_needed})
                    begin
                        found_reg <= 1'b1;
                        ans_reg <= cand;
                        lo_reg <= mid_reg + (PenW+1)'(1);
                    end
                    else
                    begin
                        hi_reg <= mid_reg - (PenW+1)'(1);
                    end
                end
                CMD_DONE:
                begin
                    if (!found_reg || ans_reg < 0) total_reg <= '0;
                    else if (ans_reg > $signed({5'd0, TotalMax})) total_reg <= TotalMax;
                    else total_reg <= ans_reg[TotalW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.sort_done = slev_reg[CostW];
    assign status.par_done = pidx_reg >= nodes_reg;
    assign status.picks_done = !wleft && !bleft;
    assign status.edge_ok = cur_reg[9:0] < nodes_reg && cur_reg[19:10] < nodes_reg;
    assign status.find_done = fphase_reg && fpar_reg == fnode && fside_reg;
    assign status.search_done = lo_reg > hi_reg;
    assign total_cost = total_reg;
    assign found = found_reg;

endmodule

// ===== rtl/cstc_ctrl.sv =====
module cstc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              out_taken,
    input  cstc_pkg::status_t status,
    output cstc_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              out_valid
);
    import cstc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SINIT, S_SORT, S_PINIT, S_PAR, S_RD, S_RD2, S_PICK,
        S_CHK, S_FIND, S_UNITE, S_PEND, S_CHECK, S_DONE, S_OUT
    } state_t;

    state_t state_reg;

    always_comb
    begin
        case (state_reg)
            S_SINIT: cmd = CMD_SORT_INIT;
            S_SORT:  cmd = CMD_SORT_STEP;
            S_PINIT: cmd = CMD_PASS_INIT;
            S_PAR:   cmd = status.par_done ? CMD_NONE : CMD_PAR_INIT;
            S_RD:    cmd = CMD_PICK_READ;
            S_PICK:  cmd = CMD_PICK;
            S_FIND:  cmd = CMD_FIND;
            S_UNITE: cmd = CMD_UNITE;
            S_PEND:  cmd = CMD_PASS_END;
            S_DONE:  cmd = CMD_DONE;
            default: cmd = CMD_NONE;
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:  if (start) state_reg <= S_SINIT;
                S_SINIT: state_reg <= S_SORT;
                S_SORT:  if (status.sort_done) state_reg <= S_CHECK;
                S_CHECK: state_reg <= status.search_done ? S_DONE : S_PINIT;
                S_PINIT: state_reg <= S_PAR;
                S_PAR:   if (status.par_done) state_reg <= S_RD;
                S_RD:    state_reg <= status.picks_done ? S_PEND : S_RD2;
                S_RD2:   state_reg <= S_PICK;
                S_PICK:  state_reg <= S_CHK;
                S_CHK:   state_reg <= status.edge_ok ? S_FIND : S_RD;
                S_FIND:
                begin
                    if (status.find_done) state_reg <= S_UNITE;
                end
                S_UNITE: state_reg <= S_RD;
                S_PEND:  state_reg <= S_CHECK;
                S_DONE:  state_reg <= S_OUT;
                S_OUT:   if (out_taken) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/constrained_spanning_tree_cost_core.sv =====
// Constrained spanning tree cost. Edges stream in one beat per cycle while the
// core is idle and are stored (up to 4096; extra ones are dropped). The beat
// with tlast starts the search: a counting sort over the 128 cost levels,
// then a bisection over penalties -100..100 (up to 8 Kruskal passes).
// Each pass resets the union-find table and walks every edge in merged order:
// read, pick and range check, and for an edge in range a find on both ends
// through the parent memory and a unite. One result beat (total_cost, found)
// follows; no new edge is taken until it has been delivered. An edge whose
// endpoint is not below node_count is skipped; total_cost saturates to
// 0..131071.
module constrained_spanning_tree_cost_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // from_node[9:0], to_node[19:10], edge_cost[26:20], edge_color[27]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // total_cost[16:0], found[17]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cstc_pkg::*;

    logic [NodeCntW-1:0] node_count_reg;
    logic [NodeW-1:0]    white_needed_reg;
    cmd_t    cmd;
    status_t status;
    logic busy, out_valid, beat_in, start;
    logic [TotalW-1:0] total_cost;
    logic found;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NodeCntW'(1);
            white_needed_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case ({1'b0, paddr[2]})
                AddrNodeCount:   node_count_reg <= pwdata[NodeCntW-1:0];
                AddrWhiteNeeded: white_needed_reg <= pwdata[NodeW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case ({1'b0, paddr[2]})
            AddrNodeCount:   prdata = {21'd0, node_count_reg};
            AddrWhiteNeeded: prdata = {22'd0, white_needed_reg};
            default:         prdata = '0;
        endcase
    end

    // accept edges only while idle: no search running and no result pending
    assign s_tready = !busy;
    assign beat_in = s_tvalid && s_tready;
    assign start = beat_in && s_tlast;

    cstc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_taken (m_tready),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    cstc_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .load_en      (beat_in),
        .load_edge    (s_tdata[EdgeW-1:0]),
        .clear_total  (out_valid && m_tready),
        .node_count   (node_count_reg),
        .white_needed (white_needed_reg),
        .total_cost   (total_cost),
        .found        (found)
    );

    assign m_tvalid = out_valid;
    assign m_tdata = {6'd0, found, total_cost};

endmodule

// ===== bench/cstc_checker.sv =====
`timescale 1ns / 1ps

module cstc_checker
    import cstc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic             found;
        logic [TotalW-1:0] total_cost;
    } tree_result_t;

    logic [EdgeW-1:0]    graph_edges [MaxEdges];
    int                  graph_size;
    int                  uf_parent [MaxNodes];
    int                  white_list [MaxEdges];
    int                  black_list [MaxEdges];
    int                  white_cnt;
    int                  black_cnt;
    logic [NodeCntW-1:0] nodes_reg;
    logic [9:0]          white_reg;
    tree_result_t        tree_q[$];

    function automatic int cost_of(input int idx);
        return int'(graph_edges[idx][26:20]);
    endfunction

    function automatic int uf_root(input int v);
        int r;
        r = v;
        while (uf_parent[r] != r) begin
            uf_parent[r] = uf_parent[uf_parent[r]];
            r = uf_parent[r];
        end
        return r;
    endfunction

    // Kruskal pass at one penalty; returns whites taken, weight via output.
    function automatic int kruskal_pass(input int pen, input int nodes, output longint weight);
        int     wi;
        int     bi;
        int     whites;
        int     idx;
        int     p;
        int     q;
        int     fa;
        int     fb;
        bit     pick_white;
        longint sum;
        wi = 0;
        bi = 0;
        whites = 0;
        sum = 0;
        for (int v = 0; v < nodes; v++) uf_parent[v] = v;
        while (wi < white_cnt || bi < black_cnt) begin
            if (wi >= white_cnt) pick_white = 0;
            else if (bi >= black_cnt) pick_white = 1;
            else pick_white = (cost_of(white_list[wi]) + pen) <= cost_of(black_list[bi]);
            if (pick_white) begin
                idx = white_list[wi];
                wi++;
            end
            else begin
                idx = black_list[bi];
                bi++;
            end
            fa = int'(graph_edges[idx][9:0]);
            fb = int'(graph_edges[idx][19:10]);
            if (fa < nodes && fb < nodes) begin
                p = uf_root(fa);
                q = uf_root(fb);
                if (p != q) begin
                    uf_parent[q] = p;
                    sum += cost_of(idx);
                    if (pick_white) begin
                        whites++;
                        sum += pen;
                    end
                end
            end
        end
        weight = sum;
        return whites;
    endfunction

    function automatic tree_result_t constrained_tree_cost();
        int           nodes;
        int           lo;
        int           hi;
        int           mid;
        int           whites;
        longint       w;
        longint       answer;
        tree_result_t r;
        nodes = (int'(nodes_reg) > MaxNodes) ? MaxNodes : int'(nodes_reg);
        white_cnt = 0;
        black_cnt = 0;
        for (int c = 0; c < 128; c++) begin
            for (int i = 0; i < graph_size; i++) begin
                if (cost_of(i) == c) begin
                    if (graph_edges[i][27] == 1'b0) white_list[white_cnt++] = i;
                    else black_list[black_cnt++] = i;
                end
            end
        end
        lo = -100;
        hi = 100;
        r.found = 1'b0;
        answer = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            whites = kruskal_pass(mid, nodes, w);
            if (whites >= int'(white_reg)) begin
                r.found = 1'b1;
                answer = w - longint'(white_reg) * mid;
                lo = mid + 1;
            end
            else hi = mid - 1;
        end
        if (!r.found || answer < 0) answer = 0;
        if (answer > 131071) answer = 131071;
        r.total_cost = answer[TotalW-1:0];
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    initial outstanding = 0;

    always @(posedge clk or negedge rst_n)
    begin
        tree_result_t want;
        if (!rst_n) begin
            graph_size <= 0;
            nodes_reg <= 1;
            white_reg <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if ({1'b0, paddr[2]} == AddrNodeCount) nodes_reg <= pwdata[NodeCntW-1:0];
                else if ({1'b0, paddr[2]} == AddrWhiteNeeded) white_reg <= pwdata[9:0];
            end
            if (s_tvalid && s_tready) begin
                if (graph_size < MaxEdges) begin
                    graph_edges[graph_size] = s_tdata[EdgeW-1:0];
                    graph_size = graph_size + 1;
                end
                if (s_tlast) begin
                    tree_q.push_back(constrained_tree_cost());
                    graph_size = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (tree_q.size() == 0) begin
                    report("unexpected result beat, total_cost", int'(m_tdata[16:0]), -1);
                end
                else begin
                    want = tree_q.pop_front();
                    if (m_tdata[16:0] !== want.total_cost)
                        report("total_cost", int'(m_tdata[16:0]), int'(want.total_cost));
                    if (m_tdata[17] !== want.found)
                        report("found", int'(m_tdata[17]), int'(want.found));
                end
            end
            outstanding = tree_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cstc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // from_node[9:0], to_node[19:10], edge_cost[26:20], edge_color[27]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // total_cost[16:0], found[17]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;

    // Sender burst state and receiver long hold-off request.
    int          burst_left;
    bit          long_hold;
    int          edges_sent;
    int          cur_nodes;

    constrained_spanning_tree_cost_core dut (.*);

    cstc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Watchdog: reports a failure and ends the run if it has not finished
    // by the limit below; each graph here is small, so the whole run stays
    // well inside it and the limit leaves ample margin.
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 8000000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random stall patterns in turn; honor one long hold-off
    // so the block sits on its result and backs up the edge stream.
    initial
    begin
        int mode;
        m_tready = 0;
        forever
        begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (4000) @(posedge clk);
                long_hold = 0;
            end
            else begin
                mode = $urandom_range(0, 3);
                repeat (64)
                begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 1) == 1);
                        2: m_tready <= ($urandom_range(0, 7) == 0);
                        default: m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one edge beat and hold it until accepted; gaps fall between bursts.
    task automatic send_edge(input int from_v, input int to_v, input int cost,
                             input bit color, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, color, cost[6:0], to_v[9:0], from_v[9:0]};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        edges_sent++;
    endtask

    // Drop valid and hold until every expected result is back, then let the
    // block settle before touching registers.
    task automatic drain;
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx[0], 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input int nodes, input int whites);
        drain();
        reg_write(AddrNodeCount, nodes);
        reg_write(AddrWhiteNeeded, whites);
        cur_nodes = nodes;
    endtask

    // One random graph; most endpoints in range, some anywhere in 10 bits.
    task automatic random_graph(input int n_edges);
        int lim;
        int a;
        int b;
        int c;
        lim = (cur_nodes < 1) ? 1 : ((cur_nodes > 1024) ? 1024 : cur_nodes);
        for (int i = 0; i < n_edges; i++)
        begin
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            else begin
                a = $urandom_range(0, lim - 1);
                b = $urandom_range(0, lim - 1);
            end
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
            send_edge(a, b, c, $urandom_range(0, 1), i == n_edges - 1);
        end
    endtask

    initial
    begin
        int nodes;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        burst_left = 0;
        long_hold = 0;
        edges_sent = 0;
        cur_nodes = 1;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero and max costs, self loop, out-of-range endpoint,
        // cost above 100, white/black tie.
        configure(4, 1);
        send_edge(0, 1, 0, 0, 0);
        send_edge(1, 2, 100, 1, 0);
        send_edge(2, 3, 127, 0, 0);
        send_edge(0, 3, 5, 1, 0);
        send_edge(1023, 0, 50, 0, 0);
        send_edge(1, 3, 5, 0, 0);
        send_edge(3, 3, 10, 0, 1);
        // Node count zero: no vertex is valid.
        configure(0, 0);
        send_edge(0, 0, 0, 0, 1);
        // Node count beyond the store, white demand never met.
        configure(2047, 1023);
        send_edge(1023, 512, 7, 0, 0);
        send_edge(0, 1023, 9, 1, 1);
        // Full vertex range, disconnected graph.
        configure(1024, 0);
        send_edge(1023, 1022, 100, 1, 0);
        send_edge(0, 1, 1, 0, 0);
        send_edge(682, 341, 64, 0, 1);

        // Random phases; register settings change between phases.
        for (int phase = 0; edges_sent < 650; phase++)
        begin
            nodes = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(2, 16);
            configure(nodes, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 8));
            if (phase == 2) long_hold = 1;
            repeat ($urandom_range(2, 6)) random_graph($urandom_range(1, 16));
        end

        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cstc_pkg.sv
rtl/cstc_datapath.sv
rtl/cstc_ctrl.sv
rtl/constrained_spanning_tree_cost_core.sv
bench/cstc_checker.sv
bench/testbench.sv
